/* design/hvt_pkg.sv */
`timescale 1ns / 1ps

package hvt_pkg;

  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int STORE_SIDE  = 4;
  localparam int STORE_DEPTH = STORE_SIDE * STORE_SIDE;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int DIM_DEFAULT = 4;
  localparam int PROD_W      = 2 * VAL_W;
  // four exact products summed need two guard bits
  localparam int SUM_W       = PROD_W + 2;
  localparam int SHIFT_W     = SUM_W - FRAC_W;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic        [IDX_W-1:0] entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] vec_x;
    logic signed [VAL_W-1:0] vec_y;
    logic signed [VAL_W-1:0] vec_z;
    logic signed [VAL_W-1:0] vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] res_x;
    logic signed [VAL_W-1:0] res_y;
    logic signed [VAL_W-1:0] res_z;
    logic signed [VAL_W-1:0] res_w;
    logic                    saturated;
  } out_item_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  // element index is row*STORE_SIDE+column, as in the matrix
  typedef prod_t [STORE_DEPTH-1:0] prod_set_t;

endpackage

/* design/hvt_stream_if.sv */
`timescale 1ns / 1ps

interface hvt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/hvt_mul_stage.sv */
`timescale 1ns / 1ps

module hvt_mul_stage #(
  parameter int DIM = hvt_pkg::DIM_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  hvt_stream_if.sink   in_ch,
  hvt_stream_if.source prod_ch
);

  logic                                               s0_valid_r;
  hvt_pkg::in_item_t                                  s0_item_r;
  logic [hvt_pkg::STORE_DEPTH-1:0][hvt_pkg::VAL_W-1:0] matrix_r;
  logic                                               prod_valid_r;
  hvt_pkg::prod_set_t                                 prod_r;
  hvt_pkg::prod_set_t                                 prod_nxt;
  logic signed [hvt_pkg::VAL_W-1:0]                   vec [hvt_pkg::STORE_SIDE];
  logic                                               s0_is_load;
  logic                                               s0_fire;
  logic                                               in_fire;

  assign s0_is_load = (s0_item_r.op == hvt_pkg::OP_LOAD);
  // a load retires on its own; a transform needs room in the product register
  assign s0_fire  = s0_valid_r && (s0_is_load || !prod_valid_r || prod_ch.ready);
  assign in_ch.ready = !s0_valid_r || s0_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign vec[0] = s0_item_r.vec_x;
  assign vec[1] = s0_item_r.vec_y;
  assign vec[2] = s0_item_r.vec_z;
  assign vec[3] = s0_item_r.vec_w;

  for (genvar gj = 0; gj < hvt_pkg::STORE_SIDE; gj++) begin : g_row
    for (genvar gi = 0; gi < hvt_pkg::STORE_SIDE; gi++) begin : g_col
      if (gj < DIM && gi < DIM) begin : g_mac
        assign prod_nxt[gj*hvt_pkg::STORE_SIDE+gi] =
          vec[gj] * $signed(matrix_r[gj*hvt_pkg::STORE_SIDE+gi]);
      end else begin : g_unused
        assign prod_nxt[gj*hvt_pkg::STORE_SIDE+gi] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_fire) begin
      s0_valid_r <= 1'b1;
    end else if (s0_fire) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_item_r <= in_ch.data;
    end
  end

  // write in item order, so a transform sees exactly the loads ahead of it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
    end else if (s0_fire && s0_is_load) begin
      matrix_r[s0_item_r.entry_index] <= s0_item_r.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (s0_fire && !s0_is_load) begin
      prod_valid_r <= 1'b1;
    end else if (prod_ch.ready) begin
      prod_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && !s0_is_load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_ch.valid = prod_valid_r;
  assign prod_ch.data  = prod_r;

  a_load_no_product: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && s0_is_load |=> !$rose(prod_valid_r))
    else $error("load transaction produced a product set");

  a_matrix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !(s0_fire && s0_is_load) |=> $stable(matrix_r))
    else $error("matrix changed without a load transaction");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !s0_is_load && prod_valid_r && !prod_ch.ready |-> !in_ch.ready)
    else $error("input taken while a transform is stalled");

endmodule

/* design/hvt_sum_stage.sv */
`timescale 1ns / 1ps

module hvt_sum_stage #(
  parameter int DIM = hvt_pkg::DIM_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  hvt_stream_if.sink   prod_ch,
  hvt_stream_if.source out_ch
);

  logic                              out_valid_r;
  hvt_pkg::out_item_t                out_item_r;
  hvt_pkg::out_item_t                out_item_nxt;
  logic signed [hvt_pkg::VAL_W-1:0]  res [hvt_pkg::STORE_SIDE];
  logic        [hvt_pkg::STORE_SIDE-1:0] clip;
  logic                              prod_fire;

  assign prod_ch.ready = !out_valid_r || out_ch.ready;
  assign prod_fire     = prod_ch.valid && prod_ch.ready;

  // column sums, floor to Q16.16, clip to 32 bits
  always_comb begin
    logic signed [hvt_pkg::SUM_W-1:0]   sum;
    logic        [hvt_pkg::SHIFT_W-1:0] shifted;
    logic [hvt_pkg::SHIFT_W-hvt_pkg::VAL_W:0] upper;
    for (int i = 0; i < hvt_pkg::STORE_SIDE; i++) begin
      sum = '0;
      for (int j = 0; j < DIM; j++) begin
        sum = sum + hvt_pkg::SUM_W'(prod_ch.data[j*hvt_pkg::STORE_SIDE+i]);
      end
      shifted = sum[hvt_pkg::SUM_W-1:hvt_pkg::FRAC_W];
      upper   = shifted[hvt_pkg::SHIFT_W-1:hvt_pkg::VAL_W-1];
      clip[i] = !((&upper) || !(|upper));
      if (clip[i]) begin
        // positive overflow goes to the largest value, negative to the smallest
        res[i] = {shifted[hvt_pkg::SHIFT_W-1],
                  {(hvt_pkg::VAL_W-1){~shifted[hvt_pkg::SHIFT_W-1]}}};
      end else begin
        res[i] = shifted[hvt_pkg::VAL_W-1:0];
      end
    end
  end

  always_comb begin
    out_item_nxt.res_x     = res[0];
    out_item_nxt.res_y     = res[1];
    out_item_nxt.res_z     = res[2];
    out_item_nxt.res_w     = res[3];
    out_item_nxt.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (prod_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  a_product_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    prod_fire |=> out_valid_r)
    else $error("accepted product set did not reach the output register");

  a_stall_holds_products: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !prod_ch.ready)
    else $error("product set taken while result is stalled");

endmodule

/* design/homogeneous_vector_transform.sv */
`timescale 1ns / 1ps
// Pipeline: a transform transaction passes through the input register, the product
// register and the result register before its result shows on out_chan.
// Throughput: one transaction per cycle unless out_chan stalls; loads give no result.
// Reset (rst_n low, synchronous) empties all stages and clears the matrix to zero.

module homogeneous_vector_transform #(
  parameter int DIM = hvt_pkg::DIM_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  hvt_stream_if.sink   in_chan,
  hvt_stream_if.source out_chan
);

  // Sixteen products of the row vector with the matrix, one per entry,
  // travel as one transaction between the multiply and the sum stage.
  hvt_stream_if #(.payload_t(hvt_pkg::prod_set_t)) prod_ch ();

  // Hold the input transaction, write the matrix on loads and
  // register the exact Q32.32 products for transforms.
  hvt_mul_stage #(
    .DIM (DIM)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_chan),
    .prod_ch (prod_ch)
  );

  // Add each column of products exactly, drop the low fraction bits
  // (floor), clip to 32 bits and flag the clip.
  hvt_sum_stage #(
    .DIM (DIM)
  ) u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .prod_ch (prod_ch),
    .out_ch  (out_chan)
  );

endmodule
